// ===== rtl/core/tbdc_pkg.sv =====
package tbdc_pkg;

	localparam int GROUP_COUNT     = 25;
	localparam int SLOTS_PER_GROUP = 256;
	localparam int TOTAL_SLOTS     = GROUP_COUNT * SLOTS_PER_GROUP;
	localparam int ADDR_W          = 13;
	localparam int KEY_W           = 41;
	localparam int ENTRY_W         = KEY_W + 1;

	localparam logic [4:0] FLAT_GROUP  = 5'd24;
	localparam logic [2:0] CLASS_MAX   = 3'd4;
	localparam logic [7:0] HASH_Y_MASK = 8'hF0;

	typedef enum logic [1:0] {
		STAT_HIT    = 2'd0,
		STAT_INSERT = 2'd1,
		STAT_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic [4:0]  group;
		logic [7:0]  start;
		logic [7:0]  block_x;
		logic [7:0]  block_y;
		logic        textured;
		logic [23:0] colour;
		logic [15:0] coord;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  size_group;
		logic [7:0]  slot_index;
		logic [7:0]  list_position;
		logic [7:0]  block_x;
		logic [7:0]  block_y;
		logic [15:0] coord_record;
	} result_t;

	function automatic logic [2:0] size_class(input logic [9:0] extent);
		logic [10:0] v;
		logic [2:0]  n;
		v = ({1'b0, extent} + 11'd1) >> 2;
		priority if (v >= 11'd16) n = CLASS_MAX;
		else if (v >= 11'd8) n = 3'd3;
		else if (v >= 11'd4) n = 3'd2;
		else if (v >= 11'd2) n = 3'd1;
		else n = 3'd0;
		return n;
	endfunction

endpackage

// ===== rtl/core/tbdc_if.sv =====
interface tbdc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [9:0] corner_a_x;
	logic [9:0] corner_a_y;
	logic [9:0] corner_b_x;
	logic [9:0] corner_b_y;
	logic [9:0] corner_c_x;
	logic [9:0] corner_c_y;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, req_type, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
		corner_c_x, corner_c_y, red, green, blue, input ready);
	modport sink(input valid, req_type, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
		corner_c_x, corner_c_y, red, green, blue, output ready);
endinterface

interface tbdc_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  size_group;
	logic [7:0]  slot_index;
	logic [7:0]  list_position;
	logic [7:0]  block_x;
	logic [7:0]  block_y;
	logic [15:0] coord_record;

	modport source(output valid, status, size_group, slot_index, list_position, block_x,
		block_y, coord_record, input ready);
	modport sink(input valid, status, size_group, slot_index, list_position, block_x,
		block_y, coord_record, output ready);
endinterface

// ===== rtl/core/tbdc_front.sv =====
module tbdc_front import tbdc_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     busy,
	tbdc_req_if.sink req,
	input  logic     q_full,
	output logic     q_push,
	output request_t q_data
);

	logic                  valid_s1;
	logic                  flat_s1;
	logic [9:0]            ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic [23:0]           colour_s1;
	logic [15:0]           coord_s1;
	logic [COORD_BITS-1:0] cnt_q;
	logic [15:0]           cnt16;
	logic                  accept;

	logic signed [11:0] ax, ay, bx, by, cx, cy;
	logic signed [11:0] dw, dh, ws, hs, w, h, x, y;
	logic [9:0]         ux, uy;
	logic [2:0]         wc, hc;
	logic [4:0]         cls;
	logic [7:0]         bxu, byu;

	generate
		if (COORD_BITS >= 16) begin : g_wide
			assign cnt16 = cnt_q[15:0];
		end else begin : g_narrow
			assign cnt16 = {{(16-COORD_BITS){1'b0}}, cnt_q};
		end
	endgenerate

	assign q_push    = valid_s1 && !q_full;
	assign req.ready = !busy && (!valid_s1 || q_push);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				cnt_q    <= cnt_q + 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flat_s1   <= req.req_type;
			ax_s1     <= req.corner_a_x;
			ay_s1     <= req.corner_a_y;
			bx_s1     <= req.corner_b_x;
			by_s1     <= req.corner_b_y;
			cx_s1     <= req.corner_c_x;
			cy_s1     <= req.corner_c_y;
			colour_s1 <= {req.blue, req.green, req.red};
			coord_s1  <= cnt16;
		end
	end

	always_comb begin
		ax = {2'b00, ax_s1};
		ay = {2'b00, ay_s1};
		bx = {2'b00, bx_s1};
		by = {2'b00, by_s1};
		cx = {2'b00, cx_s1};
		cy = {2'b00, cy_s1};
		dw = cx - ax;
		dh = cy - ay;
		ws = (dw == 12'sd0) ? (bx - ax) : dw;
		hs = (dh == 12'sd0) ? (by - ay) : dh;
		w  = ws[11] ? -ws : ws;
		h  = hs[11] ? -hs : hs;

		x = ax;
		y = ay;
		priority if (ax < bx) begin
			if (ay <= cy) begin
				if (cy > by) begin
					x = bx - w;
					y = by;
				end
			end else if (cx > ax) begin
				x = cx - w;
				y = cy;
			end else begin
				x = cx;
				y = cy;
			end
		end else if (ax == bx) begin
			if (ay < by) begin
				if (!(cx > ax)) x = ax - w;
			end else if (ay > by) begin
				priority if (bx < cx) begin
					x = bx;
					y = by;
				end else if (cy > by) begin
					x = bx - w;
					y = by;
				end else begin
					x = cx;
					y = cy;
				end
			end
		end else begin
			priority if (by > cy) begin
				if (cx > bx) begin
					x = bx;
					y = by - h;
				end else begin
					x = cx;
					y = cy;
				end
			end else if (by < cy) begin
				x = bx;
				y = by;
			end else if (ay > cy) begin
				x = bx;
				y = by;
			end else begin
				x = ax - w;
			end
		end

		ux  = x[11] ? 10'd0 : x[9:0];
		uy  = y[11] ? 10'd0 : y[9:0];
		bxu = ux[9:2];
		byu = uy[9:2];
		wc  = size_class(w[9:0]);
		hc  = size_class(h[9:0]);
		cls = {hc, 2'b00} + {2'b00, hc} + {2'b00, wc};

		q_data.textured = !flat_s1;
		q_data.colour   = colour_s1;
		q_data.coord    = coord_s1;
		if (flat_s1) begin
			q_data.group   = FLAT_GROUP;
			q_data.start   = 8'd0;
			q_data.block_x = 8'd0;
			q_data.block_y = 8'd0;
		end else begin
			q_data.group   = FLAT_GROUP - cls;
			q_data.start   = (byu & HASH_Y_MASK) + {4'd0, bxu[7:4]};
			q_data.block_x = bxu;
			q_data.block_y = byu;
		end
	end

endmodule

// ===== rtl/core/tbdc_queue.sv =====
module tbdc_queue import tbdc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  request_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output request_t pop_data
);

	request_t   data_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) data_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/core/tbdc_back.sv =====
module tbdc_back import tbdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	output logic       busy,
	input  logic       q_valid,
	input  request_t   q_data,
	output logic       q_pop,
	tbdc_res_if.source res
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_PROBE = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	request_t            cur_q;
	logic [8:0]          issue_cnt_q;
	logic [8:0]          chk_cnt_q;
	logic                rd_pend_q;
	logic [7:0]          rd_slot_q;
	logic [ENTRY_W-1:0]  rd_data_q;
	logic [8:0]          fill_q [GROUP_COUNT];
	result_t             pend_q;
	result_t             out_q;
	logic                out_valid_q;

	logic [ENTRY_W-1:0]  mem [TOTAL_SLOTS];
	logic [ADDR_W-1:0]   rd_addr;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	logic                wr_en;
	logic [7:0]          issue_slot;
	logic [KEY_W-1:0]    key;
	logic                evict_free;
	logic                is_empty;
	logic                is_hit;
	logic                out_free;

	assign busy       = (state_q == S_CLEAR);
	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign issue_slot = cur_q.start + issue_cnt_q[7:0];
	assign rd_addr    = {cur_q.group, issue_slot};
	assign key        = {cur_q.textured, cur_q.block_x, cur_q.block_y, cur_q.colour};
	assign is_empty   = !rd_data_q[KEY_W];
	assign is_hit     = rd_data_q[KEY_W-1:0] == key;
	assign evict_free = rd_pend_q && (state_q == S_PROBE);
	assign out_free   = !out_valid_q || res.ready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {cur_q.group, rd_slot_q};
		wr_data = {1'b1, key};
		if (state_q == S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else if (evict_free && is_empty) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			rd_pend_q   <= 1'b0;
			issue_cnt_q <= '0;
			chk_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			for (int g = 0; g < GROUP_COUNT; g++) fill_q[g] <= '0;
		end else begin
			if (state_q == S_EMIT && out_free) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(TOTAL_SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					rd_pend_q   <= 1'b0;
					issue_cnt_q <= '0;
					chk_cnt_q   <= '0;
					if (q_valid) state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (!issue_cnt_q[8]) issue_cnt_q <= issue_cnt_q + 1'b1;
					if (rd_pend_q) chk_cnt_q <= chk_cnt_q + 1'b1;
					if (rd_pend_q && is_empty)
						fill_q[cur_q.group] <= fill_q[cur_q.group] + 9'd1;
					if (rd_pend_q && (is_empty || is_hit || chk_cnt_q == 9'd255)) begin
						rd_pend_q <= 1'b0;
						state_q   <= S_EMIT;
					end else begin
						rd_pend_q <= !issue_cnt_q[8];
					end
				end
				S_EMIT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
		if (evict_free) begin
			pend_q.size_group   <= cur_q.group;
			pend_q.block_x      <= cur_q.block_x;
			pend_q.block_y      <= cur_q.block_y;
			pend_q.coord_record <= cur_q.coord;
			priority if (is_empty) begin
				pend_q.status        <= STAT_INSERT;
				pend_q.slot_index    <= rd_slot_q;
				pend_q.list_position <= fill_q[cur_q.group][7:0];
			end else if (is_hit) begin
				pend_q.status        <= STAT_HIT;
				pend_q.slot_index    <= rd_slot_q;
				pend_q.list_position <= 8'd0;
			end else begin
				pend_q.status        <= STAT_FULL;
				pend_q.slot_index    <= 8'd0;
				pend_q.list_position <= 8'd0;
			end
		end
		if (state_q == S_PROBE) rd_slot_q <= issue_slot;
		if (state_q == S_EMIT && out_free) out_q <= pend_q;
	end

	assign res.valid         = out_valid_q;
	assign res.status        = out_q.status;
	assign res.size_group    = out_q.size_group;
	assign res.slot_index    = out_q.slot_index;
	assign res.list_position = out_q.list_position;
	assign res.block_x       = out_q.block_x;
	assign res.block_y       = out_q.block_y;
	assign res.coord_record  = out_q.coord_record;

endmodule

// ===== rtl/core/texture_block_dedup_cache.sv =====
// Texture block de-duplication cache: each word is classified (size group, upper-left
// block corner, hash) by a front stage and queued; a back stage then probes the group's
// 256-slot table one slot per cycle through a single-read-port slot memory, returning a
// hit, an insert or a table-full status plus a coord-record index. The back stage takes
// one item at a time and pops the next word only once the last result has gone to the
// output register. After reset a clearing pass sweeps every slot of the slot memory;
// req.ready stays low until it ends. Results are held in an output register, so a
// waiting result lets one more word be probed; classifying halts when the queue fills.
module texture_block_dedup_cache import tbdc_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	tbdc_req_if.sink   req,
	tbdc_res_if.source res
);

	logic     busy;
	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_valid;
	request_t q_in;
	request_t q_out;

	tbdc_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (busy),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	tbdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_out)
	);

	tbdc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (busy),
		.q_valid (q_valid),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule

// ===== rtl/core/tbdc_checker.sv =====
module tbdc_checker import tbdc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  status,
	input logic [4:0]  size_group,
	input logic [7:0]  slot_index,
	input logic [7:0]  list_position
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(slot_index))
		else $error("result word dropped or changed while stalled");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_FULL |-> slot_index == 8'd0 && list_position == 8'd0)
		else $error("full status with nonzero slot or position");

	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == STAT_HIT |-> list_position == 8'd0)
		else $error("hit with nonzero list position");

	a_group: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> size_group <= FLAT_GROUP)
		else $error("size group out of range");

endmodule

bind texture_block_dedup_cache tbdc_checker u_tbdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.status        (res.status),
	.size_group    (res.size_group),
	.slot_index    (res.slot_index),
	.list_position (res.list_position)
);
